/* rtl/pcc_pkg.sv */
// Shared widths, codes and word types of the point cloud covariance block.
package pcc_pkg;

   // Set size and field widths
   localparam int MAX_POINTS = 4096;
   localparam int COORD_W    = 24;
   localparam int LOG_N      = $clog2(MAX_POINTS);
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);
   localparam int CSUM_W     = COORD_W + LOG_N;
   localparam int PROD_W     = 2 * COORD_W;
   localparam int PSUM_W     = PROD_W + LOG_N;
   localparam int MEAN_W     = 24;
   localparam int VAR_W      = 47;
   localparam int COV_W      = 48;
   localparam int TOTAL_W    = 13;

   // Point queue between front and back
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

   // Finalize datapath: signed numerator, magnitude/quotient, divisor
   localparam int ACC_W    = CNT_W + PSUM_W + 1;
   localparam int QUO_W    = ACC_W - 1;
   localparam int MUL_W    = CSUM_W;
   localparam int DIV_W    = 2 * CNT_W;
   localparam int STEP_W   = $clog2(QUO_W);
   localparam int NUM_JOBS = 9;

   // Saturation limits on result magnitudes
   localparam logic [QUO_W-1:0] MEAN_POS_LIM = QUO_W'((64'd1 << (MEAN_W - 1)) - 64'd1);
   localparam logic [QUO_W-1:0] MEAN_NEG_LIM = QUO_W'(64'd1 << (MEAN_W - 1));
   localparam logic [QUO_W-1:0] COV_POS_LIM  = QUO_W'((64'd1 << (COV_W - 1)) - 64'd1);
   localparam logic [QUO_W-1:0] COV_NEG_LIM  = QUO_W'(64'd1 << (COV_W - 1));

   typedef enum logic [1:0] {
      AX_X = 2'd0,
      AX_Y = 2'd1,
      AX_Z = 2'd2
   } axis_type;

   typedef enum logic [2:0] {
      P_XX = 3'd0,
      P_XY = 3'd1,
      P_XZ = 3'd2,
      P_YY = 3'd3,
      P_YZ = 3'd4,
      P_ZZ = 3'd5
   } prod_type;

   // One finalize job per result field
   typedef enum logic [3:0] {
      JOB_MX = 4'd0,
      JOB_MY = 4'd1,
      JOB_MZ = 4'd2,
      JOB_XX = 4'd3,
      JOB_XY = 4'd4,
      JOB_XZ = 4'd5,
      JOB_YY = 4'd6,
      JOB_YZ = 4'd7,
      JOB_ZZ = 4'd8
   } job_type;

   typedef struct packed {
      logic [COORD_W-1:0] z;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] x;
      logic               last;
   } pt_type;

   typedef struct packed {
      logic [2:0][CSUM_W-1:0] csum;
      logic [5:0][PSUM_W-1:0] psum;
      logic [CNT_W-1:0]       count;
   } sums_type;

endpackage

/* rtl/pcc_front.sv */
// Front end: accepts point words and queues them, tagged with the last flag.
module pcc_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [pcc_pkg::COORD_W-1:0]  req_coord_x,
   input  logic [pcc_pkg::COORD_W-1:0]  req_coord_y,
   input  logic [pcc_pkg::COORD_W-1:0]  req_coord_z,
   input  logic                         req_last_point,
   output pcc_pkg::pt_type              q_word,
   output logic                         q_valid,
   input  logic                         q_pop
);
   import pcc_pkg::*;

   pt_type             mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_AW:0]   cnt_ff, cnt_in;
   logic               push;
   pt_type             word_in;

   // Accept while the queue has room
   assign busy    = (cnt_ff == (FIFO_AW + 1)'(FIFO_DEPTH));
   assign push    = start && !busy;
   assign q_valid = (cnt_ff != '0);
   assign q_word  = mem_ff[rd_ptr_ff];

   always_comb begin
      word_in.x    = req_coord_x;
      word_in.y    = req_coord_y;
      word_in.z    = req_coord_z;
      word_in.last = req_last_point;
   end

   // Advance pointers with wrap, track fill
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!push && q_pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Store the word
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= word_in;
      end
   end

endmodule

/* rtl/pcc_accum.sv */
// Back end, first part: product pipeline and running sums of one point set.
module pcc_accum (
   input  logic               clock,
   input  logic               reset,
   input  pcc_pkg::pt_type    q_word,
   input  logic               q_valid,
   output logic               q_pop,
   output logic               job_valid,
   output pcc_pkg::sums_type  job,
   input  logic               solve_busy
);
   import pcc_pkg::*;

   logic                    s1_valid_ff;
   pt_type                  s1_pt_ff;
   logic                    s2_valid_ff;
   pt_type                  s2_pt_ff;
   logic [5:0][PROD_W-1:0]  s2_prod_ff;
   logic [5:0][PROD_W-1:0]  prod;
   logic [2:0][COORD_W-1:0] s2_c;
   logic [2:0][CSUM_W-1:0]  csum_ff, csum_in;
   logic [5:0][PSUM_W-1:0]  psum_ff, psum_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    advance;
   logic                    take;

   // Hold the pipeline while a finished set waits for the solver
   assign advance   = !(s2_valid_ff && s2_pt_ff.last && solve_busy);
   assign q_pop     = advance && q_valid;
   assign job_valid = advance && s2_valid_ff && s2_pt_ff.last;

   // Six second-moment products of the point in stage one
   always_comb begin
      prod[P_XX] = $signed(s1_pt_ff.x) * $signed(s1_pt_ff.x);
      prod[P_XY] = $signed(s1_pt_ff.x) * $signed(s1_pt_ff.y);
      prod[P_XZ] = $signed(s1_pt_ff.x) * $signed(s1_pt_ff.z);
      prod[P_YY] = $signed(s1_pt_ff.y) * $signed(s1_pt_ff.y);
      prod[P_YZ] = $signed(s1_pt_ff.y) * $signed(s1_pt_ff.z);
      prod[P_ZZ] = $signed(s1_pt_ff.z) * $signed(s1_pt_ff.z);
   end

   // Add the point unless the set is already full
   always_comb begin
      s2_c[AX_X] = s2_pt_ff.x;
      s2_c[AX_Y] = s2_pt_ff.y;
      s2_c[AX_Z] = s2_pt_ff.z;
      take       = s2_valid_ff && (cnt_ff < CNT_W'(MAX_POINTS));
      csum_in    = csum_ff;
      psum_in    = psum_ff;
      cnt_in     = cnt_ff;
      if (take) begin
         for (int i = 0; i < 3; i++) begin
            csum_in[i] = csum_ff[i]
               + {{(CSUM_W - COORD_W){s2_c[i][COORD_W-1]}}, s2_c[i]};
         end
         for (int j = 0; j < 6; j++) begin
            psum_in[j] = psum_ff[j]
               + {{(PSUM_W - PROD_W){s2_prod_ff[j][PROD_W-1]}}, s2_prod_ff[j]};
         end
         cnt_in = cnt_ff + 1'b1;
      end
      job.csum  = csum_in;
      job.psum  = psum_in;
      job.count = cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         csum_ff     <= '0;
         psum_ff     <= '0;
         cnt_ff      <= '0;
      end else if (advance) begin
         s1_valid_ff <= q_valid;
         s2_valid_ff <= s1_valid_ff;
         // Clear the sums once a set is handed off
         if (s2_valid_ff && s2_pt_ff.last) begin
            csum_ff <= '0;
            psum_ff <= '0;
            cnt_ff  <= '0;
         end else begin
            csum_ff <= csum_in;
            psum_ff <= psum_in;
            cnt_ff  <= cnt_in;
         end
      end
   end

   // Stage payload
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_pt_ff   <= q_word;
         s2_pt_ff   <= s1_pt_ff;
         s2_prod_ff <= prod;
      end
   end

endmodule

/* rtl/pcc_solve.sv */
// Back end, second part: shift-add multiplier and restoring divider for the results.
module pcc_solve (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               job_valid,
   input  pcc_pkg::sums_type                  job,
   output logic                               solve_busy,
   output logic                               rsp_valid,
   output logic signed [pcc_pkg::MEAN_W-1:0]  rsp_mean_x,
   output logic signed [pcc_pkg::MEAN_W-1:0]  rsp_mean_y,
   output logic signed [pcc_pkg::MEAN_W-1:0]  rsp_mean_z,
   output logic        [pcc_pkg::VAR_W-1:0]   rsp_var_xx,
   output logic signed [pcc_pkg::COV_W-1:0]   rsp_cov_xy,
   output logic signed [pcc_pkg::COV_W-1:0]   rsp_cov_xz,
   output logic        [pcc_pkg::VAR_W-1:0]   rsp_var_yy,
   output logic signed [pcc_pkg::COV_W-1:0]   rsp_cov_yz,
   output logic        [pcc_pkg::VAR_W-1:0]   rsp_var_zz,
   output logic        [pcc_pkg::TOTAL_W-1:0] rsp_point_total
);
   import pcc_pkg::*;

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_LOAD  = 9'b000000010,
      ST_MUL_A = 9'b000000100,
      ST_MUL_B = 9'b000001000,
      ST_ABS   = 9'b000010000,
      ST_RND   = 9'b000100000,
      ST_DIV   = 9'b001000000,
      ST_SAT   = 9'b010000000,
      ST_EMIT  = 9'b100000000
   } state_type;

   state_type         state_ff, state_in;
   job_type           job_ff, job_in;
   sums_type          snap_ff, snap_in;
   logic [CNT_W-1:0]  n_ff, n_in;
   logic [DIV_W-1:0]  dsq_ff, dsq_in;
   logic [DIV_W-1:0]  n_wide;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [ACC_W-1:0]  mcand_ff, mcand_in;
   logic [MUL_W-1:0]  mplier_ff, mplier_in;
   logic              sub_ff, sub_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              neg_ff, neg_in;
   logic [QUO_W-1:0]  mag_ff, mag_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [DIV_W:0]    rem_ff, rem_in;
   logic [DIV_W-1:0]  div_ff, div_in;
   logic [COV_W-1:0]  res_ff [NUM_JOBS];
   logic              res_wr;

   // Job decode
   logic              is_mean, is_var;
   axis_type          ax_a, ax_b;
   prod_type          pidx;
   logic [CSUM_W-1:0] ca, cb, ca_mag, cb_mag;
   logic [PSUM_W-1:0] ps, ps_mag;
   logic [ACC_W-1:0]  mul_sum, acc_neg;
   logic [DIV_W:0]    shifted;
   logic [DIV_W+1:0]  trial;
   logic [QUO_W-1:0]  lim, clamp, signed_val;
   logic [COV_W-1:0]  sat_val;

   always_comb begin
      is_mean = 1'b0;
      is_var  = 1'b0;
      ax_a    = AX_X;
      ax_b    = AX_X;
      pidx    = P_XX;
      case (job_ff)
         JOB_MX: begin is_mean = 1'b1; ax_a = AX_X; end
         JOB_MY: begin is_mean = 1'b1; ax_a = AX_Y; end
         JOB_MZ: begin is_mean = 1'b1; ax_a = AX_Z; end
         JOB_XX: begin is_var = 1'b1; ax_a = AX_X; ax_b = AX_X; pidx = P_XX; end
         JOB_XY: begin ax_a = AX_X; ax_b = AX_Y; pidx = P_XY; end
         JOB_XZ: begin ax_a = AX_X; ax_b = AX_Z; pidx = P_XZ; end
         JOB_YY: begin is_var = 1'b1; ax_a = AX_Y; ax_b = AX_Y; pidx = P_YY; end
         JOB_YZ: begin ax_a = AX_Y; ax_b = AX_Z; pidx = P_YZ; end
         JOB_ZZ: begin is_var = 1'b1; ax_a = AX_Z; ax_b = AX_Z; pidx = P_ZZ; end
         default: begin is_mean = 1'b1; end
      endcase
   end

   // Operand magnitudes, multiply step, divide step
   always_comb begin
      ca      = snap_ff.csum[ax_a];
      cb      = snap_ff.csum[ax_b];
      ps      = snap_ff.psum[pidx];
      ca_mag  = ca[CSUM_W-1] ? (~ca + 1'b1) : ca;
      cb_mag  = cb[CSUM_W-1] ? (~cb + 1'b1) : cb;
      ps_mag  = ps[PSUM_W-1] ? (~ps + 1'b1) : ps;
      mul_sum = acc_ff;
      if (mplier_ff[0]) begin
         mul_sum = sub_ff ? (acc_ff - mcand_ff) : (acc_ff + mcand_ff);
      end
      acc_neg = ~acc_ff + 1'b1;
      shifted = {rem_ff[DIV_W-1:0], quo_ff[QUO_W-1]};
      trial   = {1'b0, shifted} - {2'b00, div_ff};
   end

   // Clamp the rounded quotient to the field range, restore its sign, zero a negative variance
   always_comb begin
      if (is_mean) begin
         lim = neg_ff ? MEAN_NEG_LIM : MEAN_POS_LIM;
      end else begin
         lim = neg_ff ? COV_NEG_LIM : COV_POS_LIM;
      end
      clamp      = (quo_ff > lim) ? lim : quo_ff;
      signed_val = neg_ff ? (~clamp + 1'b1) : clamp;
      sat_val    = (is_var && neg_ff) ? '0 : signed_val[COV_W-1:0];
   end

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      job_in    = job_ff;
      snap_in   = snap_ff;
      n_in      = n_ff;
      dsq_in    = dsq_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      sub_in    = sub_ff;
      step_in   = step_ff;
      neg_in    = neg_ff;
      mag_in    = mag_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      div_in    = div_ff;
      res_wr    = 1'b0;
      n_wide    = DIV_W'(n_ff);
      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               snap_in  = job;
               n_in     = (job.count == '0) ? CNT_W'(1) : job.count;
               n_wide   = DIV_W'(n_in);
               dsq_in   = n_wide * n_wide;
               job_in   = JOB_MX;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (is_mean) begin
               acc_in   = {{(ACC_W - CSUM_W){ca[CSUM_W-1]}}, ca};
               div_in   = DIV_W'(n_ff);
               state_in = ST_ABS;
            end else begin
               // num = n * S_ab - S_a * S_b, built by signed shift-add
               acc_in    = '0;
               mcand_in  = ACC_W'(ps_mag);
               mplier_in = MUL_W'(n_ff);
               sub_in    = ps[PSUM_W-1];
               step_in   = '0;
               div_in    = dsq_ff;
               state_in  = ST_MUL_A;
            end
         end
         ST_MUL_A: begin
            acc_in    = mul_sum;
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            step_in   = step_ff + 1'b1;
            if (step_ff == STEP_W'(MUL_W - 1)) begin
               mcand_in  = ACC_W'(ca_mag);
               mplier_in = cb_mag;
               sub_in    = (ca[CSUM_W-1] == cb[CSUM_W-1]);
               step_in   = '0;
               state_in  = ST_MUL_B;
            end
         end
         ST_MUL_B: begin
            acc_in    = mul_sum;
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            step_in   = step_ff + 1'b1;
            if (step_ff == STEP_W'(MUL_W - 1)) begin
               state_in = ST_ABS;
            end
         end
         ST_ABS: begin
            neg_in   = acc_ff[ACC_W-1];
            mag_in   = acc_ff[ACC_W-1] ? acc_neg[QUO_W-1:0] : acc_ff[QUO_W-1:0];
            state_in = ST_RND;
         end
         ST_RND: begin
            quo_in   = mag_ff + QUO_W'(div_ff >> 1);
            rem_in   = '0;
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // One quotient bit per cycle
            quo_in  = {quo_ff[QUO_W-2:0], ~trial[DIV_W+1]};
            rem_in  = trial[DIV_W+1] ? shifted : trial[DIV_W:0];
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(QUO_W - 1)) begin
               state_in = ST_SAT;
            end
         end
         ST_SAT: begin
            res_wr = 1'b1;
            if (job_ff == JOB_ZZ) begin
               state_in = ST_EMIT;
            end else begin
               job_in   = job_type'(job_ff + 1'b1);
               state_in = ST_LOAD;
            end
         end
         ST_EMIT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         job_ff   <= JOB_MX;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         job_ff   <= job_in;
         step_ff  <= step_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      snap_ff   <= snap_in;
      n_ff      <= n_in;
      dsq_ff    <= dsq_in;
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      sub_ff    <= sub_in;
      neg_ff    <= neg_in;
      mag_ff    <= mag_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      div_ff    <= div_in;
      if (res_wr) begin
         res_ff[job_ff] <= sat_val;
      end
   end

   // Result word
   assign solve_busy      = (state_ff != ST_IDLE);
   assign rsp_valid       = (state_ff == ST_EMIT);
   assign rsp_mean_x      = res_ff[JOB_MX][MEAN_W-1:0];
   assign rsp_mean_y      = res_ff[JOB_MY][MEAN_W-1:0];
   assign rsp_mean_z      = res_ff[JOB_MZ][MEAN_W-1:0];
   assign rsp_var_xx      = res_ff[JOB_XX][VAR_W-1:0];
   assign rsp_cov_xy      = res_ff[JOB_XY];
   assign rsp_cov_xz      = res_ff[JOB_XZ];
   assign rsp_var_yy      = res_ff[JOB_YY][VAR_W-1:0];
   assign rsp_cov_yz      = res_ff[JOB_YZ];
   assign rsp_var_zz      = res_ff[JOB_ZZ][VAR_W-1:0];
   assign rsp_point_total = TOTAL_W'(snap_ff.count);

endmodule

/* rtl/point_cloud_covariance.sv */
// Top level: population covariance and centroid of a streamed 3D point set.
//
//   channel   handshake          word
//   --------  -----------------  ------------------------------------------------
//   request   start / busy       req_coord_x, req_coord_y, req_coord_z, req_last_point
//   response  rsp_valid strobe   rsp_mean_*, rsp_var_*, rsp_cov_*, rsp_point_total
//
// Points are taken one per cycle while the queue has room into a four-word queue and
// summed through a two-stage product pipeline. A set's last point starts the finalize
// sequencer, a shift-add multiplier and a restoring divider (one quotient bit per cycle);
// while it runs, the next set keeps accumulating until its own last point reaches the
// sums. Reset clears the queue and the sums.
// busy rises only when the queue is full; the response strobe lasts one cycle.
module point_cloud_covariance (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic signed [pcc_pkg::COORD_W-1:0] req_coord_x,
   input  logic signed [pcc_pkg::COORD_W-1:0] req_coord_y,
   input  logic signed [pcc_pkg::COORD_W-1:0] req_coord_z,
   input  logic                               req_last_point,
   output logic                               rsp_valid,
   output logic signed [pcc_pkg::MEAN_W-1:0]  rsp_mean_x,
   output logic signed [pcc_pkg::MEAN_W-1:0]  rsp_mean_y,
   output logic signed [pcc_pkg::MEAN_W-1:0]  rsp_mean_z,
   output logic        [pcc_pkg::VAR_W-1:0]   rsp_var_xx,
   output logic signed [pcc_pkg::COV_W-1:0]   rsp_cov_xy,
   output logic signed [pcc_pkg::COV_W-1:0]   rsp_cov_xz,
   output logic        [pcc_pkg::VAR_W-1:0]   rsp_var_yy,
   output logic signed [pcc_pkg::COV_W-1:0]   rsp_cov_yz,
   output logic        [pcc_pkg::VAR_W-1:0]   rsp_var_zz,
   output logic        [pcc_pkg::TOTAL_W-1:0] rsp_point_total
);
   import pcc_pkg::*;

   pt_type   q_word;
   logic     q_valid;
   logic     q_pop;
   logic     job_valid;
   sums_type job;
   logic     solve_busy;

   // Accept and queue points
   pcc_front u_front (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_coord_x    (req_coord_x),
      .req_coord_y    (req_coord_y),
      .req_coord_z    (req_coord_z),
      .req_last_point (req_last_point),
      .q_word         (q_word),
      .q_valid        (q_valid),
      .q_pop          (q_pop)
   );

   // Accumulate sums, hand off finished sets
   pcc_accum u_accum (
      .clock      (clock),
      .reset      (reset),
      .q_word     (q_word),
      .q_valid    (q_valid),
      .q_pop      (q_pop),
      .job_valid  (job_valid),
      .job        (job),
      .solve_busy (solve_busy)
   );

   // Compute centroid and covariance
   pcc_solve u_solve (
      .clock           (clock),
      .reset           (reset),
      .job_valid       (job_valid),
      .job             (job),
      .solve_busy      (solve_busy),
      .rsp_valid       (rsp_valid),
      .rsp_mean_x      (rsp_mean_x),
      .rsp_mean_y      (rsp_mean_y),
      .rsp_mean_z      (rsp_mean_z),
      .rsp_var_xx      (rsp_var_xx),
      .rsp_cov_xy      (rsp_cov_xy),
      .rsp_cov_xz      (rsp_cov_xz),
      .rsp_var_yy      (rsp_var_yy),
      .rsp_cov_yz      (rsp_cov_yz),
      .rsp_var_zz      (rsp_var_zz),
      .rsp_point_total (rsp_point_total)
   );

endmodule

/* tb/tb_point_cloud_covariance.sv */
// Self-checking testbench for the point cloud covariance block.
module tb_point_cloud_covariance;
   import pcc_pkg::*;

   localparam int STALL_LIMIT  = 20000;
   localparam int DRAIN_CYCLES = 1500;
   localparam int RANDOM_ITEMS = 1900;
   localparam int RANDOM_SETS  = 48;

   localparam logic [COORD_W-1:0] COORD_MAX = COORD_W'((64'd1 << (COORD_W - 1)) - 64'd1);
   localparam logic [COORD_W-1:0] COORD_MIN = COORD_W'(64'd1 << (COORD_W - 1));
   localparam longint             MEAN_TOP  = (64'sd1 << (MEAN_W - 1)) - 64'sd1;
   localparam logic [127:0]       COV_TOP   = (128'd1 << (COV_W - 1)) - 128'd1;

   // Coordinate styles for generated sets
   localparam int STYLE_FULL    = 0;
   localparam int STYLE_EXTREME = 1;
   localparam int STYLE_CLUSTER = 2;
   localparam int STYLE_MIXED   = 3;

   typedef struct packed {
      logic [MEAN_W-1:0]  mean_x;
      logic [MEAN_W-1:0]  mean_y;
      logic [MEAN_W-1:0]  mean_z;
      logic [VAR_W-1:0]   var_xx;
      logic [COV_W-1:0]   cov_xy;
      logic [COV_W-1:0]   cov_xz;
      logic [VAR_W-1:0]   var_yy;
      logic [COV_W-1:0]   cov_yz;
      logic [VAR_W-1:0]   var_zz;
      logic [TOTAL_W-1:0] total;
   } moments_type;

   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic signed [COORD_W-1:0] req_coord_x;
   logic signed [COORD_W-1:0] req_coord_y;
   logic signed [COORD_W-1:0] req_coord_z;
   logic                      req_last_point;
   logic                      rsp_valid;
   logic signed [MEAN_W-1:0]  rsp_mean_x;
   logic signed [MEAN_W-1:0]  rsp_mean_y;
   logic signed [MEAN_W-1:0]  rsp_mean_z;
   logic        [VAR_W-1:0]   rsp_var_xx;
   logic signed [COV_W-1:0]   rsp_cov_xy;
   logic signed [COV_W-1:0]   rsp_cov_xz;
   logic        [VAR_W-1:0]   rsp_var_yy;
   logic signed [COV_W-1:0]   rsp_cov_yz;
   logic        [VAR_W-1:0]   rsp_var_zz;
   logic        [TOTAL_W-1:0] rsp_point_total;

   // Points waiting to be driven and set results waiting to arrive
   pt_type      point_backlog[$];
   moments_type pending_moments[$];

   // Running sums of the set being gathered
   longint coord_sum[3];
   longint moment_sum[6];
   longint points_held;

   bit word_taken;
   bit steady;
   int gap_left;
   int idle_cycles;
   int fail_count;

   point_cloud_covariance DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_coord_x     (req_coord_x),
      .req_coord_y     (req_coord_y),
      .req_coord_z     (req_coord_z),
      .req_last_point  (req_last_point),
      .rsp_valid       (rsp_valid),
      .rsp_mean_x      (rsp_mean_x),
      .rsp_mean_y      (rsp_mean_y),
      .rsp_mean_z      (rsp_mean_z),
      .rsp_var_xx      (rsp_var_xx),
      .rsp_cov_xy      (rsp_cov_xy),
      .rsp_cov_xz      (rsp_cov_xz),
      .rsp_var_yy      (rsp_var_yy),
      .rsp_cov_yz      (rsp_cov_yz),
      .rsp_var_zz      (rsp_var_zz),
      .rsp_point_total (rsp_point_total)
   );

   always #1 clock = ~clock;

   // Centroid: sum over count, rounded half away from zero, clamped
   function automatic logic [MEAN_W-1:0] centroid_of(longint total, longint n);
      longint mag;
      longint q;
      longint v;
      mag = (total < 0) ? -total : total;
      q   = (mag + n / 2) / n;
      if (total < 0)
         v = (q > MEAN_TOP + 1) ? -(MEAN_TOP + 1) : -q;
      else
         v = (q > MEAN_TOP) ? MEAN_TOP : q;
      return MEAN_W'(v);
   endfunction

   // Covariance entry: (n*Sab - Sa*Sb) / n^2 in full width, rounded, clamped
   function automatic logic [COV_W-1:0] covariance_of(longint sa, longint sb, longint sab,
                                                      longint n, bit is_var);
      logic signed [127:0] num;
      logic [127:0]        mag;
      logic [127:0]        q;
      logic [127:0]        d;
      bit                  neg;
      num = 128'(n) * 128'(sab) - 128'(sa) * 128'(sb);
      neg = num[127];
      mag = neg ? -num : num;
      d   = 128'(n * n);
      q   = (mag + d / 2) / d;
      if (is_var)
         return neg ? '0 : ((q > COV_TOP) ? COV_W'(COV_TOP) : COV_W'(q));
      if (neg)
         return (q > COV_TOP + 1) ? COV_W'(-(COV_TOP + 1)) : COV_W'(-q);
      return (q > COV_TOP) ? COV_W'(COV_TOP) : COV_W'(q);
   endfunction

   // Close out the current set into one result word
   function automatic moments_type settle_set();
      moments_type w;
      longint      n;
      n        = (points_held != 0) ? points_held : 1;
      w.mean_x = centroid_of(coord_sum[AX_X], n);
      w.mean_y = centroid_of(coord_sum[AX_Y], n);
      w.mean_z = centroid_of(coord_sum[AX_Z], n);
      w.var_xx = VAR_W'(covariance_of(coord_sum[AX_X], coord_sum[AX_X], moment_sum[P_XX],
                                      n, 1'b1));
      w.cov_xy = covariance_of(coord_sum[AX_X], coord_sum[AX_Y], moment_sum[P_XY], n, 1'b0);
      w.cov_xz = covariance_of(coord_sum[AX_X], coord_sum[AX_Z], moment_sum[P_XZ], n, 1'b0);
      w.var_yy = VAR_W'(covariance_of(coord_sum[AX_Y], coord_sum[AX_Y], moment_sum[P_YY],
                                      n, 1'b1));
      w.cov_yz = covariance_of(coord_sum[AX_Y], coord_sum[AX_Z], moment_sum[P_YZ], n, 1'b0);
      w.var_zz = VAR_W'(covariance_of(coord_sum[AX_Z], coord_sum[AX_Z], moment_sum[P_ZZ],
                                      n, 1'b1));
      w.total  = TOTAL_W'(points_held);
      return w;
   endfunction

   // Fold one accepted point into the sums; emit an expectation on the last one
   task automatic accumulate_point(pt_type p);
      longint x;
      longint y;
      longint z;
      x = longint'(signed'(p.x));
      y = longint'(signed'(p.y));
      z = longint'(signed'(p.z));
      if (points_held < MAX_POINTS) begin
         coord_sum[AX_X]  += x;
         coord_sum[AX_Y]  += y;
         coord_sum[AX_Z]  += z;
         moment_sum[P_XX] += x * x;
         moment_sum[P_XY] += x * y;
         moment_sum[P_XZ] += x * z;
         moment_sum[P_YY] += y * y;
         moment_sum[P_YZ] += y * z;
         moment_sum[P_ZZ] += z * z;
         points_held++;
      end
      if (p.last) begin
         pending_moments.push_back(settle_set());
         foreach (coord_sum[i]) coord_sum[i] = 0;
         foreach (moment_sum[i]) moment_sum[i] = 0;
         points_held = 0;
      end
   endtask

   task automatic check_field(input string field, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         fail_count++;
         if (fail_count <= 10)
            $display("mismatch on %s: expected %h, got %h", field, want, got);
      end
   endtask

   task automatic queue_point(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                              logic [COORD_W-1:0] z, logic last);
      pt_type p;
      p.x    = x;
      p.y    = y;
      p.z    = z;
      p.last = last;
      point_backlog.push_back(p);
   endtask

   function automatic logic [COORD_W-1:0] draw_coord(int style, logic [COORD_W-1:0] center);
      case (style)
         STYLE_FULL: begin
            return COORD_W'($urandom());
         end
         STYLE_EXTREME: begin
            case ($urandom_range(0, 4))
               0:       return COORD_MAX;
               1:       return COORD_MIN;
               2:       return '0;
               3:       return COORD_W'(1);
               default: return '1;
            endcase
         end
         default: begin
            return center + COORD_W'($urandom_range(0, 511)) - COORD_W'(256);
         end
      endcase
   endfunction

   // Queue one set of points, flagging the final one as last
   task automatic queue_set(int count, int style);
      logic [COORD_W-1:0] cx;
      logic [COORD_W-1:0] cy;
      logic [COORD_W-1:0] cz;
      int                 s;
      cx = COORD_W'($urandom());
      cy = COORD_W'($urandom());
      cz = COORD_W'($urandom());
      for (int i = 0; i < count; i++) begin
         s = (style == STYLE_MIXED) ? $urandom_range(STYLE_FULL, STYLE_CLUSTER) : style;
         queue_point(draw_coord(s, cx), draw_coord(s, cy), draw_coord(s, cz), i == count - 1);
      end
   endtask

   // Drive the next point at the falling edge; hold a point until it is taken
   always @(negedge clock) begin
      pt_type item;
      if (!reset && !(start && !word_taken)) begin
         if (gap_left > 0) begin
            start <= 1'b0;
            gap_left--;
         end else if (point_backlog.size() != 0) begin
            item = point_backlog.pop_front();
            req_coord_x    <= item.x;
            req_coord_y    <= item.y;
            req_coord_z    <= item.z;
            req_last_point <= item.last;
            start          <= 1'b1;
            // switch between back-to-back stretches and random gaps now and then
            if ($urandom_range(0, 99) == 0)
               steady = !steady;
            gap_left = steady ? 0 : $urandom_range(0, 5);
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Check results, track accepted points and watch for a hang
   always @(posedge clock) begin
      moments_type want;
      pt_type      seen;
      if (reset) begin
         word_taken  = 1'b0;
         idle_cycles = 0;
      end else begin
         word_taken = start && !busy;
         if (rsp_valid) begin
            if (pending_moments.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("result word with no set pending: total %0d", rsp_point_total);
            end else begin
               want = pending_moments.pop_front();
               check_field("mean_x", 64'(want.mean_x), 64'({rsp_mean_x}));
               check_field("mean_y", 64'(want.mean_y), 64'({rsp_mean_y}));
               check_field("mean_z", 64'(want.mean_z), 64'({rsp_mean_z}));
               check_field("var_xx", 64'(want.var_xx), 64'({rsp_var_xx}));
               check_field("cov_xy", 64'(want.cov_xy), 64'({rsp_cov_xy}));
               check_field("cov_xz", 64'(want.cov_xz), 64'({rsp_cov_xz}));
               check_field("var_yy", 64'(want.var_yy), 64'({rsp_var_yy}));
               check_field("cov_yz", 64'(want.cov_yz), 64'({rsp_cov_yz}));
               check_field("var_zz", 64'(want.var_zz), 64'({rsp_var_zz}));
               check_field("point_total", 64'(want.total), 64'({rsp_point_total}));
            end
         end
         if (word_taken) begin
            seen.x    = req_coord_x;
            seen.y    = req_coord_y;
            seen.z    = req_coord_z;
            seen.last = req_last_point;
            accumulate_point(seen);
         end
         idle_cycles = (word_taken || rsp_valid) ? 0 : idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   initial begin
      int random_points;
      int random_sets;
      int size;
      clock          = 1'b0;
      reset          = 1'b1;
      start          = 1'b0;
      req_coord_x    = '0;
      req_coord_y    = '0;
      req_coord_z    = '0;
      req_last_point = 1'b0;
      steady         = 1'b0;
      gap_left       = 0;
      fail_count     = 0;
      points_held    = 0;
      random_points  = 0;
      random_sets    = 0;
      foreach (coord_sum[i]) coord_sum[i] = 0;
      foreach (moment_sum[i]) moment_sum[i] = 0;

      // single-point sets at the coordinate extremes
      queue_point(COORD_MAX, COORD_MIN, '0, 1'b1);
      queue_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);
      // widest spread: largest variances and covariances of greatest magnitude
      queue_point(COORD_MAX, COORD_MIN, COORD_MAX, 1'b0);
      queue_point(COORD_MIN, COORD_MAX, COORD_MIN, 1'b1);
      // rounding ties in both directions for means and covariances
      queue_point('0, '0, '0, 1'b0);
      queue_point(COORD_W'(1), COORD_W'(2), COORD_W'(-2), 1'b1);
      queue_point('0, '0, '0, 1'b0);
      queue_point(COORD_W'(-1), COORD_W'(-1), COORD_W'(1), 1'b1);
      // identical points give zero covariance
      repeat (4) queue_point(COORD_MAX, COORD_MAX, COORD_MIN, 1'b0);
      queue_point(COORD_MAX, COORD_MAX, COORD_MIN, 1'b1);
      // thirds
      queue_point(COORD_W'(1), '0, COORD_W'(-1), 1'b0);
      queue_point(COORD_W'(2), '0, '0, 1'b0);
      queue_point('0, COORD_W'(5), COORD_W'(7), 1'b1);
      // alternating extremes on every axis
      for (int i = 0; i < 6; i++)
         queue_point(i[0] ? COORD_MAX : COORD_MIN, i[1] ? COORD_MIN : COORD_MAX,
                     i[0] ? COORD_MIN : COORD_MAX, i == 5);

      // random sets, mostly short
      while (random_points < RANDOM_ITEMS || random_sets < RANDOM_SETS) begin
         case ($urandom_range(0, 19)) inside
            [0:13]:  size = $urandom_range(1, 8);
            [14:17]: size = $urandom_range(9, 64);
            default: size = $urandom_range(65, 300);
         endcase
         queue_set(size, $urandom_range(STYLE_FULL, STYLE_MIXED));
         random_points += size;
         random_sets++;
      end

      repeat (4) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // wait for every point to go in and every set result to come out
      while (point_backlog.size() != 0 || start)
         @(posedge clock);
      while (pending_moments.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
